>>> sv/tdsq_pkg.sv
// tdsq_pkg: shared types and constants for the timed device service queues
// no dependencies; imported by every module of the block

package tdsq_pkg;

    localparam int NUM_REGS = 3;   // one duration register per modeled device
    localparam int DUR_W    = 16;  // duration / remaining-time width
    localparam int PID_W    = 8;   // pid field width on the ports
    localparam int DEV_FW   = 2;   // device field width
    localparam int IDX_W    = 2;   // config register index width

    // config register indexes
    localparam logic [IDX_W-1:0] REG_DISK    = 2'd0;
    localparam logic [IDX_W-1:0] REG_TAPE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRINTER = 2'd2;

    typedef logic [DUR_W-1:0] dur_t;
    typedef logic [NUM_REGS-1:0][DUR_W-1:0] dur_bank_t;

    typedef enum logic {
        KIND_ENQ  = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DONE   = 2'd1,
        ST_QUEUED = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [DEV_FW-1:0]  device;
        logic [PID_W-1:0]   pid;
    } item_t;

endpackage

>>> sv/timed_device_service_queues.sv
// timed_device_service_queues: top level with input stage, result stage and config port
// depends on tdsq_pkg, tdsq_cfg and tdsq_queues
//
// usage
//   input channel (in_valid / in_stall) carries kind, device, pid. kind enqueue
//   appends pid to the device fifo; kind tick takes one unit of service time
//   from the device's head entry and pops it when the time runs out.
//   output channel (out_valid / out_stall) returns one beat per input beat:
//   status (idle, done, queued, full) and done_pid (finished pid, else zero).
//   config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets the
//   disk, tape and printer service durations; cfg_ready is always high.
//   durations should only change while the queues are empty and idle.
// timing
//   an accepted beat passes the input register, then the result register, to
//   the output. while out_stall is low one beat per cycle is sustained: the input
//   register feeds one pass of fifo logic and the pid memory read, which land
//   in the result register; the memory takes one write and one read a cycle.
// reset
//   rst_n clears both pipeline stages, all fifo pointers and counts; the
//   durations come back as 1. the pid memory is not cleared.
// stall
//   while out_stall holds a waiting result, one more beat is taken into the
//   input register; in_stall rises only when both stages are full.

module timed_device_service_queues #(
    parameter int NUM_DEVICES = 3,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [tdsq_pkg::DEV_FW-1:0] device,
    input  logic [tdsq_pkg::PID_W-1:0]  pid,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [tdsq_pkg::PID_W-1:0]  done_pid,
    // config channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tdsq_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tdsq_pkg::DUR_W-1:0]  cfg_data
);
    import tdsq_pkg::*;

    logic      a_valid_reg;   // input stage holds a beat
    logic      a_valid_next;
    item_t     a_item_reg;
    logic      b_valid_reg;   // result stage holds a beat
    logic      b_valid_next;

    logic      in_take;       // input beat accepted this edge
    logic      out_take;      // output beat taken this edge
    logic      advance;       // input stage moves into result stage
    dur_bank_t dur;
    status_t   status_q;

    assign out_take = b_valid_reg && !out_stall;
    // result stage can load when empty or when its beat is leaving
    assign advance  = a_valid_reg && (!b_valid_reg || !out_stall);
    // hold off input only when both stages are full and the receiver stalls
    assign in_stall = a_valid_reg && b_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_take)
        begin
            a_valid_next = 1'b1;
        end
        else if (advance)
        begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (advance)
        begin
            b_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // input payload register, loaded on every accepted beat
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_item_reg.kind   <= kind_t'(kind);
            a_item_reg.device <= device;
            a_item_reg.pid    <= pid;
        end
    end

    assign cfg_ready = 1'b1;

    tdsq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .dur      (dur)
    );

    tdsq_queues #(
        .NUM_DEVICES (NUM_DEVICES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_queues (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (a_item_reg),
        .dur      (dur),
        .status   (status_q),
        .done_pid (done_pid)
    );

    assign out_valid = b_valid_reg;
    assign status    = status_q;

endmodule

>>> sv/tdsq_cfg.sv
// tdsq_cfg: service duration registers, written over the config channel
// depends on tdsq_pkg

module tdsq_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [tdsq_pkg::IDX_W-1:0] wr_index,
    input  logic [tdsq_pkg::DUR_W-1:0] wr_data,
    output tdsq_pkg::dur_bank_t       dur
);
    import tdsq_pkg::*;

    dur_bank_t dur_reg;
    dur_bank_t dur_next;

    always_comb
    begin
        dur_next = dur_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_DISK:    dur_next[0] = wr_data;
                REG_TAPE:    dur_next[1] = wr_data;
                REG_PRINTER: dur_next[2] = wr_data;
                default:     dur_next = dur_reg;  // unknown index is dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                dur_reg[i] <= DUR_W'(1);
            end
        end
        else
        begin
            dur_reg <= dur_next;
        end
    end

    assign dur = dur_reg;

endmodule

>>> sv/tdsq_queues.sv
// tdsq_queues: per-device fifo control, shared pid memory and result register
// depends on tdsq_pkg; durations come from tdsq_cfg

module tdsq_queues #(
    parameter int NUM_DEVICES = 3,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  tdsq_pkg::item_t            item,
    input  tdsq_pkg::dur_bank_t        dur,
    output tdsq_pkg::status_t          status,
    output logic [tdsq_pkg::PID_W-1:0] done_pid
);
    import tdsq_pkg::*;

    localparam int NDEV      = (NUM_DEVICES < NUM_REGS) ? NUM_DEVICES : NUM_REGS;
    localparam int DEV_W     = (NDEV > 1) ? $clog2(NDEV) : 1;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NDEV * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SW        = (PID_BITS < PID_W) ? PID_BITS : PID_W;

    logic [PTR_W-1:0] read_ptr_reg  [NDEV];
    logic [PTR_W-1:0] read_ptr_next [NDEV];
    logic [PTR_W-1:0] write_ptr_reg [NDEV];
    logic [PTR_W-1:0] write_ptr_next[NDEV];
    logic [CNT_W-1:0] fill_reg      [NDEV];
    logic [CNT_W-1:0] fill_next     [NDEV];
    dur_t             remain_reg    [NDEV];
    dur_t             remain_next   [NDEV];

    logic [SW-1:0]    pid_store_reg [MEM_DEPTH];
    logic [SW-1:0]    rd_data_reg;
    status_t          status_reg;
    status_t          status_next;

    logic             dev_ok;
    logic [DEV_W-1:0] sel;
    logic [PTR_W-1:0] rd_ptr_cur;
    logic [PTR_W-1:0] wr_ptr_cur;
    logic [CNT_W-1:0] fill_cur;
    dur_t             rem_cur;
    dur_t             rem_dec;
    dur_t             dur_cur;
    logic             wr_en;
    logic             rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    always_comb
    begin
        dev_ok     = (item.device < DEV_FW'(NDEV));
        sel        = dev_ok ? item.device[DEV_W-1:0] : '0;
        rd_ptr_cur = read_ptr_reg[sel];
        wr_ptr_cur = write_ptr_reg[sel];
        fill_cur   = fill_reg[sel];
        rem_cur    = remain_reg[sel];
        rem_dec    = rem_cur - DUR_W'(1);
        dur_cur    = dur[DEV_FW'(sel)];
        wr_addr    = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_ptr_cur);
        rd_addr    = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_ptr_cur);

        read_ptr_next  = read_ptr_reg;
        write_ptr_next = write_ptr_reg;
        fill_next      = fill_reg;
        remain_next    = remain_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        status_next    = ST_IDLE;

        if (dev_ok)
        begin
            case (item.kind)
                KIND_ENQ:
                begin
                    if (fill_cur == CNT_W'(QUEUE_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en               = 1'b1;
                        write_ptr_next[sel] = next_slot(wr_ptr_cur);
                        fill_next[sel]      = fill_cur + CNT_W'(1);
                        if (fill_cur == '0)
                        begin
                            remain_next[sel] = dur_cur;
                        end
                        status_next = ST_QUEUED;
                    end
                end
                KIND_TICK:
                begin
                    if (fill_cur != '0)
                    begin
                        remain_next[sel] = rem_dec;
                        if (rem_dec == '0)
                        begin
                            rd_en              = 1'b1;
                            read_ptr_next[sel] = next_slot(rd_ptr_cur);
                            fill_next[sel]     = fill_cur - CNT_W'(1);
                            if (fill_cur != CNT_W'(1))
                            begin
                                remain_next[sel] = dur_cur;
                            end
                            status_next = ST_DONE;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NDEV; i++)
            begin
                read_ptr_reg[i]  <= '0;
                write_ptr_reg[i] <= '0;
                fill_reg[i]      <= '0;
                remain_reg[i]    <= '0;
            end
        end
        else if (advance)
        begin
            read_ptr_reg  <= read_ptr_next;
            write_ptr_reg <= write_ptr_next;
            fill_reg      <= fill_next;
            remain_reg    <= remain_next;
        end
    end

    // pid memory: at most one write and one registered read per beat
    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            pid_store_reg[wr_addr] <= item.pid[SW-1:0];
        end
        if (advance && rd_en)
        begin
            rd_data_reg <= pid_store_reg[rd_addr];
        end
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        done_pid = '0;
        if (status_reg == ST_DONE)
        begin
            done_pid[SW-1:0] = rd_data_reg;
        end
    end

    assign status = status_reg;

endmodule

>>> sv/tdsq_check.sv
// tdsq_check: port-level assertions for timed_device_service_queues, bound to the top
// depends on tdsq_pkg

module tdsq_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [1:0]                  status,
    input logic [tdsq_pkg::PID_W-1:0]  done_pid,
    input logic                        cfg_ready
);
    import tdsq_pkg::*;

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(done_pid))
        else $error("output beat changed while stalled");

    // only a finished head carries a pid
    a_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DONE) |-> done_pid == '0)
        else $error("done_pid nonzero without a finished process");

    // input is held off only behind a stalled full result stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // an accepted beat cannot vanish: with the output empty, a result must follow
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> ##1 out_valid)
        else $error("accepted beat produced no result");

    // reset leaves no result pending and config open
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall && cfg_ready)
        else $error("pending state during reset");

endmodule

bind timed_device_service_queues tdsq_check u_tdsq_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .done_pid  (done_pid),
    .cfg_ready (cfg_ready)
);
